// ===== sv/fpq_pkg.sv =====
// Package for the flame presence qualifier: stream widths, register indexes,
// register reset values and the struct passed from the vote stage.
// No dependencies.
package fpq_pkg;

    localparam int PINS_W            = 5;
    localparam int TIME_W            = 32;
    localparam int SAMPLES_PER_CHECK = 5;
    localparam int HIGH_LIMIT        = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int THRESH_W  = 4;
    localparam int DEBOUNCE_W = 16;
    localparam int CONFIRM_W = 8;
    localparam int COUNT_W   = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_COUNT    = 2'd2;

    localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 4'd7;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET  = 16'd1000;
    localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET   = 8'd8;

    localparam logic [CONFIRM_W-1:0]  COUNTER_MAX = 8'hFF;
    localparam logic [COUNT_W-1:0]    COUNT_SAT   = 4'd15;

    typedef struct packed {
        logic               raw;
        logic [COUNT_W-1:0] count;
    } t_vote;

endpackage

// ===== sv/fpq_vote.sv =====
// Vote stage: counts high pin samples, shifts the vote into the window ring
// and keeps a running count of ones in it. Depends on fpq_pkg.
module fpq_vote #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [fpq_pkg::PINS_W-1:0]     i_pins,
    input  logic [fpq_pkg::THRESH_W-1:0]   i_threshold,
    output fpq_pkg::t_vote                 o_vote
);
    import fpq_pkg::*;

    localparam int CW = $clog2(WINDOW_LEN + 1);
    localparam int XW = (CW > THRESH_W) ? CW : THRESH_W;
    localparam int NS = (SAMPLES_PER_CHECK < PINS_W) ? SAMPLES_PER_CHECK : PINS_W;

    logic [WINDOW_LEN-1:0] r_ring;
    logic [WINDOW_LEN-1:0] n_ring;
    logic [CW-1:0]         r_ones;
    logic [CW-1:0]         n_ones;
    logic [2:0]            high_cnt;
    logic                  vote;
    logic [XW-1:0]         ones_ext;

    always_comb begin
        high_cnt = 3'd0;
        for (int i = 0; i < NS; i++) begin
            high_cnt = high_cnt + 3'(i_pins[i]);
        end
    end

    assign vote     = (high_cnt < 3'(HIGH_LIMIT));
    assign n_ring   = {r_ring[WINDOW_LEN-2:0], vote};
    assign n_ones   = r_ones - CW'(r_ring[WINDOW_LEN-1]) + CW'(vote);
    assign ones_ext = XW'(n_ones);

    always_comb begin
        o_vote.raw = (ones_ext >= XW'(i_threshold));
        if (ones_ext > XW'(COUNT_SAT)) begin
            o_vote.count = COUNT_SAT;
        end else begin
            o_vote.count = ones_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_ones <= '0;
        end else if (i_en) begin
            r_ring <= n_ring;
            r_ones <= n_ones;
        end
    end

endmodule

// ===== sv/fpq_qualify.sv =====
// Debounce and confirmation stage: tracks raw state changes, elapsed time
// and the saturating confirmation counter. Depends on fpq_pkg.
module fpq_qualify (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_raw,
    input  logic [fpq_pkg::TIME_W-1:0]      i_time,
    input  logic [fpq_pkg::DEBOUNCE_W-1:0]  i_debounce,
    input  logic [fpq_pkg::CONFIRM_W-1:0]   i_confirm,
    output logic                            o_flag
);
    import fpq_pkg::*;

    logic                  r_last_raw;
    logic [TIME_W-1:0]     r_change_time;
    logic [CONFIRM_W-1:0]  r_counter;
    logic                  r_flag;
    logic [TIME_W-1:0]     n_change_time;
    logic [CONFIRM_W-1:0]  n_counter;
    logic                  n_flag;
    logic [TIME_W-1:0]     elapsed;
    logic [CONFIRM_W-1:0]  counter_inc;
    logic [DEBOUNCE_W:0]   debounce2;

    assign n_change_time = (i_raw != r_last_raw) ? i_time : r_change_time;
    assign elapsed       = i_time - n_change_time;
    assign debounce2     = {i_debounce, 1'b0};
    assign counter_inc   = (r_counter != COUNTER_MAX) ? r_counter + 1'b1 : r_counter;

    always_comb begin
        n_counter = r_counter;
        n_flag    = r_flag;
        if (i_raw) begin
            if (elapsed > TIME_W'(i_debounce)) begin
                n_counter = counter_inc;
                if (counter_inc >= i_confirm) begin
                    n_flag = 1'b1;
                end
            end
        end else begin
            n_counter = '0;
            if (elapsed > TIME_W'(debounce2)) begin
                n_flag = 1'b0;
            end
        end
    end

    assign o_flag = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_change_time <= '0;
            r_counter     <= '0;
            r_flag        <= 1'b0;
        end else if (i_en) begin
            r_last_raw    <= i_raw;
            r_change_time <= n_change_time;
            r_counter     <= n_counter;
            r_flag        <= n_flag;
        end
    end

endmodule

// ===== sv/flame_presence_qualifier_unit.sv =====
// Flame presence qualifier top level: input register, configuration registers,
// vote and qualify stages and the result register. Depends on fpq_pkg,
// fpq_vote and fpq_qualify.
//
// Each input beat is one sensor check: five raw pin samples and a millisecond
// timestamp. Each accepted beat yields exactly one result beat with the
// confirmed flag, the window vote result and the ring count.
// The beat is captured in an input register; the vote and qualify logic is
// combinational from there into the result register, so a result beat is valid
// once its input beat moves on from the input register, which a receiver stall
// can delay. One beat per cycle is sustained while the receiver does not stall;
// the count update and the debounce compares work in the same cycle.
// When the receiver stalls, the result register holds its beat and the input
// register holds the next one; the input side stalls only when both are full.
// The configuration channel is always ready and should be written only while
// no beats are in flight. Synchronous reset empties both registers, clears the
// window ring and the debounce state, and loads threshold 7, debounce 1000 ms
// and confirm count 8.
module flame_presence_qualifier_unit #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pin_samples [4:0], time_ms [36:5], zero [39:37]
    input  logic [fpq_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // flame_confirmed [0], raw_present [1], window_count [5:2], zero [7:6]
    output logic [fpq_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpq_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fpq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpq_pkg::*;

    logic                  r_in_valid;
    logic [PINS_W-1:0]     r_in_pins;
    logic [TIME_W-1:0]     r_in_time;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;
    logic [THRESH_W-1:0]   r_threshold;
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [CONFIRM_W-1:0]  r_confirm;

    logic   out_ready;
    logic   advance;
    logic   in_take;
    t_vote  vote;
    logic   flag;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    fpq_vote #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_vote (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_pins      (r_in_pins),
        .i_threshold (r_threshold),
        .o_vote      (vote)
    );

    fpq_qualify u_qualify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_raw      (vote.raw),
        .i_time     (r_in_time),
        .i_debounce (r_debounce),
        .i_confirm  (r_confirm),
        .o_flag     (flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
            r_debounce  <= DEBOUNCE_RESET;
            r_confirm   <= CONFIRM_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                    CFG_DEBOUNCE_MS:      r_debounce  <= i_cfg_data[DEBOUNCE_W-1:0];
                    CFG_CONFIRM_COUNT:    r_confirm   <= i_cfg_data[CONFIRM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pins <= s_axis_tdata[PINS_W-1:0];
            r_in_time <= s_axis_tdata[PINS_W +: TIME_W];
        end
        if (advance) begin
            r_out_data <= {2'b00, vote.count, vote.raw, flag};
        end
    end

endmodule

// ===== sv/fpq_checker.sv =====
// Port checker for the flame presence qualifier, bound to the top level.
// Depends only on the top level's port list.
module fpq_checker #(
    parameter int WINDOW_LEN = 10
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [1:0] i_cfg_index,
    input logic [15:0] i_cfg_data
);

    localparam int MAX_SHOWN = (WINDOW_LEN > 15) ? 15 : WINDOW_LEN;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result beat shown right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result beat changed or dropped.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled while the result register is empty.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:2] <= 4'(MAX_SHOWN))
            && (m_axis_tdata[7:6] == 2'b00))
        else $error("Window count out of range or padding set.");

endmodule

bind flame_presence_qualifier_unit fpq_checker #(.WINDOW_LEN(WINDOW_LEN)) u_fpq_checker (.*);

// ===== tb/sv/flame_presence_qualifier_unit_tb.sv =====
// Self-checking testbench for flame_presence_qualifier_unit: a directed table
// and random sensor-check runs, checked against pinned table results or a behavioral vote and debounce model.
// Depends on fpq_pkg and the flame_presence_qualifier_unit RTL.
module flame_presence_qualifier_unit_tb;
    import fpq_pkg::*;

    localparam int RING_LEN       = 10;
    localparam int DIR_ROWS       = 25;
    localparam int N_PHASES       = 7;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               raw;
        logic               confirmed;
    } t_flame_result;

    typedef struct {
        logic [PINS_W-1:0]  pins;
        logic [TIME_W-1:0]  stamp;
        bit                 pinned;
        logic               confirmed;
        logic               raw;
        logic [COUNT_W-1:0] count;
    } t_check_row;

    typedef struct {
        logic [THRESH_W-1:0]   thresh;
        logic [DEBOUNCE_W-1:0] debounce;
        logic [CONFIRM_W-1:0]  confirm;
        int                    checks;
        int                    step_max;
        int                    src_idle;
        int                    sink_stall;
    } t_setting;

    typedef enum {RUN_FLAME, RUN_CLEAR, RUN_NOISE} t_run_kind;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_INDEX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data    = '0;

    // Model state and configuration, starting from the reset values.
    logic [RING_LEN-1:0]      vote_ring    = '0;
    int                       ring_pos     = 0;
    logic                     last_raw     = 1'b0;
    logic [TIME_W-1:0]        change_ms    = '0;
    logic [CONFIRM_W-1:0]     confirm_cnt  = '0;
    logic                     confirmed    = 1'b0;
    logic [THRESH_W-1:0]      cfg_thresh   = THRESHOLD_RESET;
    logic [DEBOUNCE_W-1:0]    cfg_debounce = DEBOUNCE_RESET;
    logic [CONFIRM_W-1:0]     cfg_confirm  = CONFIRM_RESET;

    t_flame_result            pending_results [$];
    bit                       row_pinned    = 1'b0;
    t_flame_result            row_want      = '0;
    logic [TIME_W-1:0]        now_ms        = '0;
    int                       src_idle_pct  = 0;
    int                       sink_stall_pct = 0;
    int                       mismatches    = 0;
    int                       checks_in     = 0;
    int                       results_out   = 0;
    int                       confirmed_seen = 0;
    int                       quiet_cycles  = 0;

    t_check_row dir_rows [DIR_ROWS] = '{
        '{5'h00, 32'd0,        1'b1, 1'b0, 1'b0, 4'd1},
        '{5'h1F, 32'd200,      1'b1, 1'b0, 1'b0, 4'd1},
        '{5'h03, 32'd400,      1'b1, 1'b0, 1'b0, 4'd2},
        '{5'h07, 32'd600,      1'b1, 1'b0, 1'b0, 4'd2},
        '{5'h18, 32'd800,      1'b1, 1'b0, 1'b0, 4'd3},
        '{5'h10, 32'd1000,     1'b1, 1'b0, 1'b0, 4'd4},
        '{5'h08, 32'd1200,     1'b1, 1'b0, 1'b0, 4'd5},
        '{5'h00, 32'd1400,     1'b1, 1'b0, 1'b0, 4'd6},
        '{5'h04, 32'd1600,     1'b1, 1'b0, 1'b1, 4'd7},
        '{5'h00, 32'd1800,     1'b1, 1'b0, 1'b1, 4'd8},
        '{5'h00, 32'd2700,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h01, 32'd2900,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h02, 32'd3100,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h04, 32'd3300,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h08, 32'd3500,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h10, 32'd3700,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h11, 32'd3900,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h06, 32'd4100,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h1F, 32'd4300,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h1E, 32'd4500,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h0F, 32'd4700,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h17, 32'd4900,     1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h1B, 32'hFFFFFF00, 1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h00, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 4'd0},
        '{5'h1F, 32'h00000064, 1'b0, 1'b0, 1'b0, 4'd0}
    };

    t_setting settings [N_PHASES] = '{
        '{4'd7,  16'd1000,  8'd8,   100, 600,   0,  0},
        '{4'd1,  16'd0,     8'd0,   120, 300,   69, 0},
        '{4'd10, 16'd65535, 8'd255, 120, 40000, 0,  69},
        '{4'd0,  16'd0,     8'd255, 280, 300,   13, 13},
        '{4'd15, 16'd500,   8'd3,   60,  400,   0,  0},
        '{4'd4,  16'd150,   8'd5,   100, 250,   69, 0},
        '{4'd2,  16'd1,     8'd1,   60,  5,     0,  69}
    };

    flame_presence_qualifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_flame_result qualify_check(input logic [PINS_W-1:0] pins,
                                                    input logic [TIME_W-1:0] stamp);
        t_flame_result     res;
        int                ones;
        logic              raw;
        logic [TIME_W-1:0] elapsed;
        vote_ring[ring_pos] = ($countones(pins) < HIGH_LIMIT);
        ring_pos = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
        ones = $countones(vote_ring);
        raw = (ones >= cfg_thresh);
        if (raw != last_raw) begin
            change_ms = stamp;
            last_raw  = raw;
        end
        elapsed = stamp - change_ms;
        if (raw) begin
            if (elapsed > {16'd0, cfg_debounce}) begin
                if (confirm_cnt != COUNTER_MAX)
                    confirm_cnt = confirm_cnt + 1'b1;
                if (confirm_cnt >= cfg_confirm)
                    confirmed = 1'b1;
            end
        end else begin
            confirm_cnt = '0;
            if (elapsed > {15'd0, cfg_debounce, 1'b0})
                confirmed = 1'b0;
        end
        res.confirmed = confirmed;
        res.raw       = raw;
        res.count     = (ones > 15) ? COUNT_SAT : ones[COUNT_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input int want_v, input int got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_flame_result got;
        t_flame_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_flame_result'(m_axis_tdata[5:0]);
                results_out++;
                if (got.confirmed)
                    confirmed_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got.confirmed !== want.confirmed)
                        flag_mismatch("flame_confirmed", int'(want.confirmed),
                                      int'(got.confirmed));
                    if (got.raw !== want.raw)
                        flag_mismatch("raw_present", int'(want.raw), int'(got.raw));
                    if (got.count !== want.count)
                        flag_mismatch("window_count", int'(want.count), int'(got.count));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_THRESHOLD: cfg_thresh   = i_cfg_data[THRESH_W-1:0];
                    CFG_DEBOUNCE_MS:      cfg_debounce = i_cfg_data[DEBOUNCE_W-1:0];
                    CFG_CONFIRM_COUNT:    cfg_confirm  = i_cfg_data[CONFIRM_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = qualify_check(s_axis_tdata[PINS_W-1:0],
                                     s_axis_tdata[PINS_W+TIME_W-1:PINS_W]);
                pending_results.push_back(row_pinned ? row_want : want);
                checks_in++;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_check(input logic [PINS_W-1:0] pins, input logic [TIME_W-1:0] stamp,
                              input bit pinned, input t_flame_result want);
        if ($urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, stamp, pins};
        row_pinned    <= pinned;
        row_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The queue is read only after the edge that accepts the last beat, so that beat is already in it.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Runs of flame votes and clear votes let the ring cross the threshold
    // and hold there long enough to debounce; noise runs mix both.
    task automatic run_random(input int n_checks, input int step_max);
        int               left;
        int               run_len;
        int               pick;
        t_run_kind        kind;
        logic [PINS_W-1:0] pins;
        left    = n_checks;
        run_len = 0;
        kind    = RUN_NOISE;
        while (left > 0) begin
            if (run_len == 0) begin
                run_len = $urandom_range(30, 3);
                pick    = $urandom_range(9, 0);
                kind    = (pick < 5) ? RUN_FLAME : (pick < 8) ? RUN_CLEAR : RUN_NOISE;
            end
            case (kind)
                RUN_FLAME: do pins = PINS_W'($urandom_range(31, 0));
                           while ($countones(pins) >= HIGH_LIMIT);
                RUN_CLEAR: do pins = PINS_W'($urandom_range(31, 0));
                           while ($countones(pins) < HIGH_LIMIT);
                default:   pins = PINS_W'($urandom_range(31, 0));
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 3)
                now_ms = $urandom;
            else if (pick < 5)
                now_ms = 32'hFFFFFFFF - $urandom_range(step_max, 0);
            else
                now_ms = now_ms + $urandom_range(step_max, 0);
            send_check(pins, now_ms, 1'b0, '0);
            run_len--;
            left--;
        end
    endtask

    initial begin : stimulus
        t_flame_result want;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < DIR_ROWS; r++) begin
            want.confirmed = dir_rows[r].confirmed;
            want.raw       = dir_rows[r].raw;
            want.count     = dir_rows[r].count;
            send_check(dir_rows[r].pins, dir_rows[r].stamp, dir_rows[r].pinned, want);
        end
        now_ms = dir_rows[DIR_ROWS-1].stamp;
        drain();
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_WINDOW_THRESHOLD, {12'd0, settings[p].thresh});
            write_reg(CFG_DEBOUNCE_MS, settings[p].debounce);
            write_reg(CFG_CONFIRM_COUNT, {8'd0, settings[p].confirm});
            src_idle_pct   = settings[p].src_idle;
            sink_stall_pct = settings[p].sink_stall;
            run_random(settings[p].checks, settings[p].step_max);
            drain();
        end
        if (pending_results.size() != 0 || results_out != checks_in) begin
            mismatches++;
            $display("%0t: result beats missing, expected %0d, actual %0d",
                     $time, checks_in, results_out);
        end
        $display("Covered %0d sensor checks and %0d result beats (%0d confirmed) over %0d",
                 checks_in, results_out, confirmed_seen, N_PHASES + 1);
        $display("register settings, with sender gaps and receiver stalls; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
